// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file of the allocator, flba_checker.
// No dependencies; the including file supplies clock, reset and the property terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FLBA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FLBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/flba_pkg.sv =====
// Package for the free-list block allocator: payload structs, codes and constants.
// No dependencies; used by free_list_block_allocator and flba_checker.
`timescale 1ns / 1ps
`default_nettype none

package flba_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int HEADER_BYTES   = 24;
    localparam int WORD_BYTES     = 8;

    localparam int REQ_W     = 20;
    localparam int HANDLE_W  = 6;
    localparam int SIZE_W    = 21;
    localparam int ADDR_W    = 32;
    localparam int TOP_W     = ADDR_W + 1;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;

    // search modes; the unused code searches from entry zero like the lowest-index mode
    localparam logic [MODE_W-1:0] MODE_LOW_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ROVING    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TIGHTEST  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_RST       = MODE_ROVING;
    localparam logic [ADDR_W-1:0] HEAP_BASE_RST  = 32'h0000_0000;
    localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = 32'hFFFF_FFFF;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_SIZE,
        ST_NO_MEM,
        ST_BAD_HANDLE
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FREE,
        S_HIT,
        S_APPEND,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic              action;
        logic [REQ_W-1:0]  request_size;
        logic [HANDLE_W-1:0] block_handle;
    } t_alloc_req;

    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] granted_handle;
        logic [ADDR_W-1:0]   data_address;
        logic [SIZE_W-1:0]   granted_size;
        logic                was_reused;
    } t_alloc_rsp;

    // round a byte count up to a whole number of words
    function automatic logic [SIZE_W-1:0] round_up(input logic [REQ_W-1:0] req);
        logic [SIZE_W-1:0] sum;
        sum = {1'b0, req} + SIZE_W'(WORD_BYTES - 1);
        return SIZE_W'((sum / WORD_BYTES) * WORD_BYTES);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/free_list_block_allocator.sv =====
// Free-list block allocator top level: sequencer, block table memory, result register.
// Depends on flba_pkg.
//
//   channel | handshake                  | payload
//   --------+----------------------------+--------------------------
//   in      | i_in_valid / o_in_stall    | i_in_data  (t_alloc_req)
//   out     | o_out_valid / i_out_stall  | o_out_data (t_alloc_rsp)
//   cfg     | i_cfg_we                   | i_cfg_index, i_cfg_wdata
//
// Allocate searches the block table with one read per cycle; an empty table skips the search,
// and a hit outside the tightest mode ends it early.
// Reset is synchronous; the table needs no clearing pass, only entries below the count are read.
// A new transaction is taken while a result waits in the output register; its own result
// then holds in the emit step until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

module free_list_block_allocator #(
    parameter int MAX_BLOCKS = flba_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire flba_pkg::t_alloc_req             i_in_data,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output flba_pkg::t_alloc_rsp                  o_out_data,
    input  wire logic                             i_cfg_we,
    input  wire logic [flba_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [flba_pkg::ADDR_W-1:0]      i_cfg_wdata
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    typedef struct packed {
        logic                          used;
        logic [flba_pkg::SIZE_W-1:0]   bytes;
        logic [flba_pkg::ADDR_W-1:0]   base;
    } t_entry;

    flba_pkg::t_state                r_state, n_state;
    logic [flba_pkg::MODE_W-1:0]     r_mode, n_mode;
    logic [flba_pkg::ADDR_W-1:0]     r_heap_limit, n_heap_limit;
    logic [flba_pkg::TOP_W-1:0]      r_heap_top, n_heap_top;
    logic [CW-1:0]                   r_count, n_count;
    logic [IW-1:0]                   r_rover, n_rover;
    logic [flba_pkg::SIZE_W-1:0]     r_need, n_need;
    logic [IW-1:0]                   r_idx, n_idx;
    logic [CW-1:0]                   r_left, n_left;
    logic                            r_chk_vld, n_chk_vld;
    logic [IW-1:0]                   r_chk_idx, n_chk_idx;
    logic                            r_found, n_found;
    logic [IW-1:0]                   r_best_idx, n_best_idx;
    t_entry                          r_best, n_best;
    flba_pkg::t_alloc_rsp            r_res, n_res;
    flba_pkg::t_alloc_rsp            r_out, n_out;
    logic                            r_out_vld, n_out_vld;

    t_entry                          r_mem [MAX_BLOCKS];
    t_entry                          r_rd;
    logic                            mem_we;
    logic [IW-1:0]                   mem_waddr;
    t_entry                          mem_wdata;
    logic                            mem_re;
    logic [IW-1:0]                   mem_raddr;

    logic                            fit;
    logic                            better;
    logic                            out_free;
    logic [flba_pkg::TOP_W-1:0]      end_sum;

    function automatic flba_pkg::t_alloc_rsp err_rsp(input flba_pkg::t_status st);
        flba_pkg::t_alloc_rsp rsp;
        rsp        = '0;
        rsp.status = st;
        return rsp;
    endfunction

    // shared compare unit: entry under check against the request and the best so far
    assign fit      = r_chk_vld && !r_rd.used && (r_rd.bytes >= r_need);
    assign better   = !r_found || (r_rd.bytes < r_best.bytes);
    assign out_free = !r_out_vld || !i_out_stall;
    assign end_sum  = r_heap_top + flba_pkg::TOP_W'(flba_pkg::HEADER_BYTES)
                      + flba_pkg::TOP_W'(r_need);

    assign o_in_stall  = (r_state != flba_pkg::S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_heap_limit = r_heap_limit;
        n_heap_top   = r_heap_top;
        n_count      = r_count;
        n_rover      = r_rover;
        n_need       = r_need;
        n_idx        = r_idx;
        n_left       = r_left;
        n_chk_vld    = r_chk_vld;
        n_chk_idx    = r_chk_idx;
        n_found      = r_found;
        n_best_idx   = r_best_idx;
        n_best       = r_best;
        n_res        = r_res;
        n_out        = r_out;
        n_out_vld    = r_out_vld;
        mem_we       = 1'b0;
        mem_waddr    = r_best_idx;
        mem_wdata    = r_best;
        mem_re       = 1'b0;
        mem_raddr    = r_idx;

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                flba_pkg::CFG_SEARCH_MODE: n_mode = i_cfg_wdata[flba_pkg::MODE_W-1:0];
                flba_pkg::CFG_HEAP_BASE: begin
                    // heap top follows the base only while the table is empty
                    if (r_count == '0) begin
                        n_heap_top = {1'b0, i_cfg_wdata};
                    end
                end
                flba_pkg::CFG_HEAP_LIMIT: n_heap_limit = i_cfg_wdata;
                default: ;
            endcase
        end

        unique case (r_state)
            flba_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_data.action == flba_pkg::ACT_FREE) begin
                        if (32'(i_in_data.block_handle) >= 32'(r_count)) begin
                            n_res   = err_rsp(flba_pkg::ST_BAD_HANDLE);
                            n_state = flba_pkg::S_EMIT;
                        end else begin
                            mem_re     = 1'b1;
                            mem_raddr  = IW'(i_in_data.block_handle);
                            n_best_idx = IW'(i_in_data.block_handle);
                            n_state    = flba_pkg::S_FREE;
                        end
                    end else if (i_in_data.request_size == '0) begin
                        n_res   = err_rsp(flba_pkg::ST_BAD_SIZE);
                        n_state = flba_pkg::S_EMIT;
                    end else begin
                        n_need    = flba_pkg::round_up(i_in_data.request_size);
                        n_found   = 1'b0;
                        n_chk_vld = 1'b0;
                        n_left    = r_count;
                        // roving search starts at the rover, falling back to entry zero
                        if (r_mode == flba_pkg::MODE_ROVING && 32'(r_rover) < 32'(r_count)) begin
                            n_idx = r_rover;
                        end else begin
                            n_idx = '0;
                        end
                        n_state = (r_count == '0) ? flba_pkg::S_APPEND : flba_pkg::S_SCAN;
                    end
                end
            end

            flba_pkg::S_SCAN: begin
                // issue one table read per cycle, wrapping at the block count
                if (r_left != '0) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx;
                    n_chk_idx = r_idx;
                    n_chk_vld = 1'b1;
                    n_left    = r_left - 1'b1;
                    if (32'(r_idx) + 32'd1 >= 32'(r_count)) begin
                        n_idx = '0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end else begin
                    n_chk_vld = 1'b0;
                end

                if (fit && (r_mode != flba_pkg::MODE_TIGHTEST || better)) begin
                    n_found    = 1'b1;
                    n_best_idx = r_chk_idx;
                    n_best     = r_rd;
                end

                if (fit && r_mode != flba_pkg::MODE_TIGHTEST) begin
                    n_state = flba_pkg::S_HIT;
                end else if (r_left == '0 && !r_chk_vld) begin
                    n_state = r_found ? flba_pkg::S_HIT : flba_pkg::S_APPEND;
                end
            end

            flba_pkg::S_HIT: begin
                mem_we         = 1'b1;
                mem_waddr      = r_best_idx;
                mem_wdata      = r_best;
                mem_wdata.used = 1'b1;
                if (r_mode == flba_pkg::MODE_ROVING) begin
                    n_rover = r_best_idx;
                end
                n_res.status         = flba_pkg::ST_OK;
                n_res.granted_handle = flba_pkg::HANDLE_W'(r_best_idx);
                n_res.data_address   = r_best.base + flba_pkg::ADDR_W'(flba_pkg::HEADER_BYTES);
                n_res.granted_size   = r_best.bytes;
                n_res.was_reused     = 1'b1;
                n_state              = flba_pkg::S_EMIT;
            end

            flba_pkg::S_FREE: begin
                mem_we               = 1'b1;
                mem_waddr            = r_best_idx;
                mem_wdata            = r_rd;
                mem_wdata.used       = 1'b0;
                n_res.status         = flba_pkg::ST_OK;
                n_res.granted_handle = flba_pkg::HANDLE_W'(r_best_idx);
                n_res.data_address   = r_rd.base + flba_pkg::ADDR_W'(flba_pkg::HEADER_BYTES);
                n_res.granted_size   = r_rd.bytes;
                n_res.was_reused     = 1'b0;
                n_state              = flba_pkg::S_EMIT;
            end

            flba_pkg::S_APPEND: begin
                if (32'(r_count) >= 32'(MAX_BLOCKS)
                    || end_sum > {1'b0, r_heap_limit}) begin
                    n_res = err_rsp(flba_pkg::ST_NO_MEM);
                end else begin
                    mem_we               = 1'b1;
                    mem_waddr            = r_count[IW-1:0];
                    mem_wdata.used       = 1'b1;
                    mem_wdata.bytes      = r_need;
                    mem_wdata.base       = r_heap_top[flba_pkg::ADDR_W-1:0];
                    n_count              = r_count + 1'b1;
                    n_heap_top           = end_sum;
                    n_res.status         = flba_pkg::ST_OK;
                    n_res.granted_handle = flba_pkg::HANDLE_W'(r_count);
                    n_res.data_address   = r_heap_top[flba_pkg::ADDR_W-1:0]
                                           + flba_pkg::ADDR_W'(flba_pkg::HEADER_BYTES);
                    n_res.granted_size   = r_need;
                    n_res.was_reused     = 1'b0;
                end
                n_state = flba_pkg::S_EMIT;
            end

            flba_pkg::S_EMIT: begin
                // hold until the output register is free
                if (out_free) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = flba_pkg::S_IDLE;
                end
            end

            default: n_state = flba_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= flba_pkg::S_IDLE;
            r_mode       <= flba_pkg::MODE_RST;
            r_heap_limit <= flba_pkg::HEAP_LIMIT_RST;
            r_heap_top   <= {1'b0, flba_pkg::HEAP_BASE_RST};
            r_count      <= '0;
            r_rover      <= '0;
            r_chk_vld    <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_heap_limit <= n_heap_limit;
            r_heap_top   <= n_heap_top;
            r_count      <= n_count;
            r_rover      <= n_rover;
            r_chk_vld    <= n_chk_vld;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_need     <= n_need;
        r_idx      <= n_idx;
        r_left     <= n_left;
        r_chk_idx  <= n_chk_idx;
        r_found    <= n_found;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    // block table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/flba_checker.sv =====
// Port-level checker for the free-list block allocator, bound to the top level.
// Depends on flba_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module flba_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire flba_pkg::t_alloc_rsp o_out_data
);

    `FLBA_ASSERT_NEXT(a_out_valid_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result transaction dropped while stalled")

    `FLBA_ASSERT_NEXT(a_out_data_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data), "result payload changed while stalled")

    `FLBA_ASSERT_IMPL(a_err_fields_zero, i_clk, i_rst_n, o_out_valid && o_out_data.status != flba_pkg::ST_OK, o_out_data.granted_handle == '0 && o_out_data.data_address == '0 && o_out_data.granted_size == '0 && !o_out_data.was_reused, "error result carries nonzero fields")

    `FLBA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken again before the current transaction finished")

    `FLBA_ASSERT_IMPL(a_reuse_is_ok, i_clk, i_rst_n, o_out_valid && o_out_data.was_reused, o_out_data.status == flba_pkg::ST_OK && o_out_data.granted_size != '0, "reused block reported without a valid grant")

endmodule

bind free_list_block_allocator flba_checker u_flba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for free_list_block_allocator: directed and random allocate/free traffic,
// checked against an in-bench model of the block table. Depends on flba_pkg and the allocator.
module tb_top;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES = 400;
    localparam int REPORT_LIMIT = 10;
    localparam logic [flba_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    flba_pkg::t_alloc_req in_data = '0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    flba_pkg::t_alloc_rsp out_data;
    logic cfg_we = 1'b0;
    logic [flba_pkg::CFG_IDX_W-1:0] cfg_index = flba_pkg::CFG_SEARCH_MODE;
    logic [flba_pkg::ADDR_W-1:0] cfg_wdata = '0;

    free_list_block_allocator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // model of the block table and registers, in their reset state
    logic [flba_pkg::ADDR_W-1:0] seg_base [flba_pkg::MAX_BLOCKS_DEF];
    logic [flba_pkg::SIZE_W-1:0] seg_bytes [flba_pkg::MAX_BLOCKS_DEF];
    bit seg_busy [flba_pkg::MAX_BLOCKS_DEF];
    int seg_count = 0;
    logic [flba_pkg::TOP_W-1:0] brk_top = {1'b0, flba_pkg::HEAP_BASE_RST};
    int rover_pos = 0;
    logic [flba_pkg::MODE_W-1:0] cfg_mode = flba_pkg::MODE_RST;
    logic [flba_pkg::ADDR_W-1:0] cfg_limit = flba_pkg::HEAP_LIMIT_RST;

    flba_pkg::t_alloc_req alloc_cmds[$];
    flba_pkg::t_alloc_rsp grants_due[$];
    int cmds_queued = 0;
    int cmds_taken = 0;
    int grant_errors = 0;
    int cycle_count = 0;
    bit cmd_fired = 1'b0;

    int burst_left = 0;
    int gap_left = 0;
    int rx_hold_req = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;
    int rx_pattern = 0;
    int rx_pattern_left = 0;

    function automatic void apply_reg_write(input logic [flba_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [flba_pkg::ADDR_W-1:0] val);
        case (idx)
            flba_pkg::CFG_SEARCH_MODE: cfg_mode = val[flba_pkg::MODE_W-1:0];
            flba_pkg::CFG_HEAP_BASE: begin
                // the heap top follows the base only while no block exists
                if (seg_count == 0) brk_top = {1'b0, val};
            end
            flba_pkg::CFG_HEAP_LIMIT: cfg_limit = val;
            default: ;
        endcase
    endfunction

    function automatic flba_pkg::t_alloc_rsp allocator_outcome(input flba_pkg::t_alloc_req cmd);
        flba_pkg::t_alloc_rsp rsp;
        logic [flba_pkg::SIZE_W-1:0] need;
        logic [flba_pkg::TOP_W:0] new_top;
        int hit;
        int start;
        int idx;
        rsp = '0;
        hit = -1;
        if (cmd.action == flba_pkg::ACT_FREE) begin
            if (cmd.block_handle >= seg_count) begin
                rsp.status = flba_pkg::ST_BAD_HANDLE;
                return rsp;
            end
            seg_busy[cmd.block_handle] = 1'b0;
            rsp.status = flba_pkg::ST_OK;
            rsp.granted_handle = cmd.block_handle;
            rsp.data_address = seg_base[cmd.block_handle] + flba_pkg::HEADER_BYTES;
            rsp.granted_size = seg_bytes[cmd.block_handle];
            return rsp;
        end
        if (cmd.request_size == 0) begin
            rsp.status = flba_pkg::ST_BAD_SIZE;
            return rsp;
        end
        need = flba_pkg::SIZE_W'(({1'b0, cmd.request_size} + (flba_pkg::WORD_BYTES - 1))
                                 & ~(flba_pkg::WORD_BYTES - 1));

        if (cfg_mode == flba_pkg::MODE_ROVING) begin
            if (seg_count > 0) begin
                start = (rover_pos >= seg_count) ? 0 : rover_pos;
                for (int n = 0; n < seg_count && hit < 0; n++) begin
                    idx = (start + n) % seg_count;
                    if (!seg_busy[idx] && seg_bytes[idx] >= need) hit = idx;
                end
                if (hit >= 0) rover_pos = hit;
            end
        end else if (cfg_mode == flba_pkg::MODE_TIGHTEST) begin
            for (int i = 0; i < seg_count; i++) begin
                if (!seg_busy[i] && seg_bytes[i] >= need &&
                    (hit < 0 || seg_bytes[i] < seg_bytes[hit])) hit = i;
            end
        end else begin
            for (int i = 0; i < seg_count && hit < 0; i++) begin
                if (!seg_busy[i] && seg_bytes[i] >= need) hit = i;
            end
        end

        if (hit >= 0) begin
            seg_busy[hit] = 1'b1;
            rsp.status = flba_pkg::ST_OK;
            rsp.granted_handle = hit[flba_pkg::HANDLE_W-1:0];
            rsp.data_address = seg_base[hit] + flba_pkg::HEADER_BYTES;
            rsp.granted_size = seg_bytes[hit];
            rsp.was_reused = 1'b1;
            return rsp;
        end
        new_top = brk_top + flba_pkg::HEADER_BYTES + need;
        if (seg_count >= flba_pkg::MAX_BLOCKS_DEF || new_top > cfg_limit) begin
            rsp.status = flba_pkg::ST_NO_MEM;
            return rsp;
        end
        seg_base[seg_count] = brk_top[flba_pkg::ADDR_W-1:0];
        seg_bytes[seg_count] = need;
        seg_busy[seg_count] = 1'b1;
        rsp.status = flba_pkg::ST_OK;
        rsp.granted_handle = seg_count[flba_pkg::HANDLE_W-1:0];
        rsp.data_address = brk_top[flba_pkg::ADDR_W-1:0] + flba_pkg::HEADER_BYTES;
        rsp.granted_size = need;
        seg_count++;
        brk_top = new_top[flba_pkg::TOP_W-1:0];
        return rsp;
    endfunction

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // accept transactions into the model and check results against the oldest expectation
    always @(posedge clk) begin
        flba_pkg::t_alloc_rsp want;
        if (!rst_n) begin
            cmd_fired = 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (grants_due.size() == 0) begin
                    grant_errors++;
                    if (grant_errors <= REPORT_LIMIT)
                        $display("unexpected result at %0t: status %0d handle %0d addr %h",
                                 $time, out_data.status, out_data.granted_handle,
                                 out_data.data_address);
                end else begin
                    want = grants_due.pop_front();
                    if (out_data.status !== want.status ||
                        out_data.granted_handle !== want.granted_handle ||
                        out_data.data_address !== want.data_address ||
                        out_data.granted_size !== want.granted_size ||
                        out_data.was_reused !== want.was_reused) begin
                        grant_errors++;
                        if (grant_errors <= REPORT_LIMIT) begin
                            $display("mismatch at %0t: expected st %0d h %0d addr %h sz %0d re %0d",
                                     $time, want.status, want.granted_handle,
                                     want.data_address, want.granted_size, want.was_reused);
                            $display("                  got st %0d h %0d addr %h sz %0d re %0d",
                                     out_data.status, out_data.granted_handle,
                                     out_data.data_address, out_data.granted_size,
                                     out_data.was_reused);
                        end
                    end
                end
            end
            cmd_fired = in_valid && !in_stall;
            if (cmd_fired) begin
                grants_due.push_back(allocator_outcome(in_data));
                cmds_taken++;
            end
        end
    end

    // sender: bursts of random length with random gaps
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || cmd_fired) begin
            if (gap_left > 0 || alloc_cmds.size() == 0) begin
                in_valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                in_valid <= 1'b1;
                in_data <= alloc_cmds.pop_front();
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                             : $urandom_range(0, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // receiver: stall pattern of its own, plus a long hold-off on request
    always @(negedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (rx_hold_req != rx_hold_seen) begin
                rx_hold_seen = rx_hold_req;
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (rx_pattern_left == 0) begin
                    rx_pattern = $urandom_range(0, 3);
                    rx_pattern_left = $urandom_range(20, 200);
                end
                rx_pattern_left--;
                case (rx_pattern)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= (rx_pattern_left % 3 == 0);
                endcase
            end
        end
    end

    function automatic void offer(input logic act, input logic [flba_pkg::REQ_W-1:0] size,
                                  input logic [flba_pkg::HANDLE_W-1:0] handle);
        flba_pkg::t_alloc_req cmd;
        cmd.action = act;
        cmd.request_size = size;
        cmd.block_handle = handle;
        alloc_cmds.push_back(cmd);
        cmds_queued++;
    endfunction

    task automatic wait_quiet();
        @(negedge clk);
        while (cmds_taken != cmds_queued || grants_due.size() != 0) @(negedge clk);
    endtask

    task automatic set_regs(input logic [flba_pkg::MODE_W-1:0] mode,
                            input logic [flba_pkg::ADDR_W-1:0] base,
                            input logic [flba_pkg::ADDR_W-1:0] limit);
        logic [flba_pkg::CFG_IDX_W-1:0] idx [3];
        logic [flba_pkg::ADDR_W-1:0] val [3];
        wait_quiet();
        repeat (SETTLE_CYCLES) @(negedge clk);
        idx = '{flba_pkg::CFG_SEARCH_MODE, flba_pkg::CFG_HEAP_BASE, flba_pkg::CFG_HEAP_LIMIT};
        val = '{{{(flba_pkg::ADDR_W - flba_pkg::MODE_W){1'b0}}, mode}, base, limit};
        for (int r = 0; r < 3; r++) begin
            cfg_we <= 1'b1;
            cfg_index <= idx[r];
            cfg_wdata <= val[r];
            apply_reg_write(idx[r], val[r]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int count, input int alloc_pct, input bit hold_off);
        int pick;
        logic [flba_pkg::REQ_W-1:0] size;
        logic [flba_pkg::HANDLE_W-1:0] handle;
        for (int k = 0; k < count; k++) begin
            // pause the sender once per phase until every result is back
            if (k == count / 2) wait_quiet();
            pick = $urandom_range(0, 99);
            if (pick < 4) size = '0;
            else if (pick < 45) size = flba_pkg::REQ_W'($urandom_range(1, 64));
            else if (pick < 75) size = flba_pkg::REQ_W'($urandom_range(1, 4096));
            else if (pick < 92) size = flba_pkg::REQ_W'($urandom_range(1, 65536));
            else size = flba_pkg::REQ_W'($urandom_range(0, (1 << flba_pkg::REQ_W) - 1));
            handle = ($urandom_range(0, 4) == 0) ? flba_pkg::HANDLE_W'($urandom_range(0, 63))
                                                 : flba_pkg::HANDLE_W'($urandom_range(0, 31));
            offer(($urandom_range(0, 99) < alloc_pct) ? flba_pkg::ACT_ALLOC : flba_pkg::ACT_FREE,
                  size, handle);
            if (hold_off && k == 0) rx_hold_req++;
        end
    endtask

    initial begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // heap placed so high that even the smallest block overruns the limit
        set_regs(flba_pkg::MODE_ROVING, 32'hFFFF_FFE0, flba_pkg::HEAP_LIMIT_RST);
        offer(flba_pkg::ACT_ALLOC, 8, 0);
        offer(flba_pkg::ACT_ALLOC, 0, 0);
        offer(flba_pkg::ACT_FREE, 0, 0);

        // table still empty, so the heap top moves with the new base
        set_regs(flba_pkg::MODE_ROVING, 32'h0000_1000, flba_pkg::HEAP_LIMIT_RST);
        offer(flba_pkg::ACT_ALLOC, 1, 0);
        offer(flba_pkg::ACT_ALLOC, 20'hF_FFFF, 0);
        offer(flba_pkg::ACT_ALLOC, 17, 0);
        offer(flba_pkg::ACT_ALLOC, 100, 0);
        offer(flba_pkg::ACT_ALLOC, 40, 0);
        offer(flba_pkg::ACT_FREE, 0, 63);
        offer(flba_pkg::ACT_FREE, 0, 1);
        offer(flba_pkg::ACT_FREE, 0, 1);
        offer(flba_pkg::ACT_FREE, 0, 3);
        offer(flba_pkg::ACT_FREE, 0, 0);
        offer(flba_pkg::ACT_ALLOC, 24, 0);
        offer(flba_pkg::ACT_ALLOC, 8, 0);
        // rover wraps past the end of the table
        offer(flba_pkg::ACT_ALLOC, 8, 0);
        offer(flba_pkg::ACT_FREE, 0, 3);
        offer(flba_pkg::ACT_FREE, 0, 1);

        set_regs(flba_pkg::MODE_LOW_FIRST, 32'h0000_0000, flba_pkg::HEAP_LIMIT_RST);
        offer(flba_pkg::ACT_ALLOC, 16, 0);
        offer(flba_pkg::ACT_FREE, 0, 1);

        set_regs(flba_pkg::MODE_TIGHTEST, 32'hFFFF_FFFF, flba_pkg::HEAP_LIMIT_RST);
        offer(flba_pkg::ACT_ALLOC, 16, 0);
        offer(flba_pkg::ACT_FREE, 0, 0);

        // limit leaves room for exactly one 16-byte block
        wait_quiet();
        set_regs(MODE_UNUSED, 32'h0000_0000,
                 brk_top[flba_pkg::ADDR_W-1:0] + flba_pkg::HEADER_BYTES + 16);
        offer(flba_pkg::ACT_ALLOC, 20'hF_FFFF, 0);
        offer(flba_pkg::ACT_ALLOC, 16, 0);
        offer(flba_pkg::ACT_ALLOC, 9, 0);

        set_regs(flba_pkg::MODE_LOW_FIRST, $urandom, flba_pkg::HEAP_LIMIT_RST);
        random_phase(80, 70, 1'b0);
        set_regs(flba_pkg::MODE_ROVING, 32'hFFFF_FFFF, flba_pkg::HEAP_LIMIT_RST);
        random_phase(80, 65, 1'b1);
        set_regs(flba_pkg::MODE_TIGHTEST, 32'h0000_0000, flba_pkg::HEAP_LIMIT_RST);
        random_phase(80, 65, 1'b0);
        set_regs(flba_pkg::MODE_TIGHTEST, $urandom, 32'h0000_0000);
        random_phase(75, 55, 1'b0);

        // large allocations until the table is full, then past it
        set_regs(flba_pkg::MODE_LOW_FIRST, $urandom, flba_pkg::HEAP_LIMIT_RST);
        for (int k = 0; k < 70; k++)
            offer(flba_pkg::ACT_ALLOC,
                  flba_pkg::REQ_W'($urandom_range(1 << 19, (1 << flba_pkg::REQ_W) - 1)),
                  flba_pkg::HANDLE_W'($urandom_range(0, 63)));

        set_regs(MODE_UNUSED, $urandom, 32'h8000_0000);
        random_phase(75, 55, 1'b1);
        set_regs(flba_pkg::MODE_ROVING, $urandom, flba_pkg::HEAP_LIMIT_RST);
        random_phase(75, 50, 1'b0);

        wait_quiet();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (grant_errors == 0 && grants_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/flba_pkg.sv
hw/rtl/free_list_block_allocator.sv
hw/rtl/flba_checker.sv
tb/sv/tb_top.sv
